[rtl/core/bwlp_pkg.sv]
// shared types, opcodes and constants for the butterworth low-pass biquad
// no dependencies; imported by the datapath, the controller and the top level
`timescale 1ns / 1ps

package bwlp_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int TS_WIDTH     = 63;
  localparam int CUT_WIDTH    = 20;
  localparam int OP_WIDTH     = 5;
  localparam int STEP_WIDTH   = 3;
  localparam int HORNER_LAST  = 5;

  localparam logic [CUT_WIDTH-1:0] CUT_RESET = 20'd10000;

  localparam logic [63:0] TEN12    = 64'd1000000000000;
  // floor(2^103 / 10^12); the quotient estimate is low by at most one
  localparam logic [63:0] RECIP_TEN12 = 64'((128'd1 << 103) / 128'd1000000000000);
  localparam logic [63:0] PI_Q30   = 64'd3373259426;
  localparam logic [63:0] SQRT2_Q30 = 64'd1518500250;
  localparam logic [31:0] TMIN_Q30 = 32'((64'd1 << 30) / 64'd100);
  localparam logic [31:0] C_LIMIT  = 32'd100 << 16;
  localparam logic [31:0] C_RESET  = 32'd1 << 16;
  localparam logic [23:0] PH_FULL_M1 = 24'hFFFFFF;
  localparam logic [23:0] PH_HALF    = 24'h800000;
  localparam logic [23:0] PH_QUARTER = 24'h400000;

  localparam logic [31:0] K7 = 32'((64'd21844 << 30) / 64'd6081075);
  localparam logic [31:0] K6 = 32'((64'd1382 << 30) / 64'd155925);
  localparam logic [31:0] K5 = 32'((64'd62 << 30) / 64'd2835);
  localparam logic [31:0] K4 = 32'((64'd17 << 30) / 64'd315);
  localparam logic [31:0] K3 = 32'((64'd2 << 30) / 64'd15);
  localparam logic [31:0] K2 = 32'((64'd1 << 30) / 64'd3);
  localparam logic [31:0] K1 = 32'd1 << 30;

  // datapath operations
  localparam logic [OP_WIDTH-1:0] OP_LOAD   = 5'd0;
  localparam logic [OP_WIDTH-1:0] OP_MOD1   = 5'd1;
  localparam logic [OP_WIDTH-1:0] OP_MULR   = 5'd2;
  localparam logic [OP_WIDTH-1:0] OP_MOD2   = 5'd3;
  localparam logic [OP_WIDTH-1:0] OP_PHASE  = 5'd4;
  localparam logic [OP_WIDTH-1:0] OP_MULX   = 5'd5;
  localparam logic [OP_WIDTH-1:0] OP_MULX2  = 5'd6;
  localparam logic [OP_WIDTH-1:0] OP_HORNER = 5'd7;
  localparam logic [OP_WIDTH-1:0] OP_MULT   = 5'd8;
  localparam logic [OP_WIDTH-1:0] OP_DIVC   = 5'd9;
  localparam logic [OP_WIDTH-1:0] OP_MULCC  = 5'd10;
  localparam logic [OP_WIDTH-1:0] OP_MULSC  = 5'd11;
  localparam logic [OP_WIDTH-1:0] OP_DIVG   = 5'd12;
  localparam logic [OP_WIDTH-1:0] OP_DIVK1  = 5'd13;
  localparam logic [OP_WIDTH-1:0] OP_DIVK2  = 5'd14;
  localparam logic [OP_WIDTH-1:0] OP_ACC0   = 5'd15;
  localparam logic [OP_WIDTH-1:0] OP_ACC1   = 5'd16;
  localparam logic [OP_WIDTH-1:0] OP_ACC2   = 5'd17;
  localparam logic [OP_WIDTH-1:0] OP_EMIT   = 5'd18;
  localparam logic [OP_WIDTH-1:0] OP_FIX1   = 5'd19;
  localparam logic [OP_WIDTH-1:0] OP_FIX2   = 5'd20;
  localparam logic [OP_WIDTH-1:0] OP_FIXP   = 5'd21;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_value;
    logic [TS_WIDTH-1:0]            timestamp_ns;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] filtered_value;
    logic                           updated;
  } out_t;

  typedef struct packed {
    logic                  go;
    logic [OP_WIDTH-1:0]   op;
    logic [STEP_WIDTH-1:0] step;
    logic                  updated;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic first;
    logic mag_zero;
    logic cut_zero;
    logic need_div;
    logic out_free;
  } stat_t;

  function automatic logic [31:0] horner_coef(input logic [STEP_WIDTH-1:0] step);
    logic [31:0] k;
    unique case (step)
      3'd0:    k = K6;
      3'd1:    k = K5;
      3'd2:    k = K4;
      3'd3:    k = K3;
      3'd4:    k = K2;
      3'd5:    k = K1;
      default: k = K1;
    endcase
    return k;
  endfunction

endpackage

[rtl/core/bwlp_mul.sv]
// 64x64 unsigned multiplier, one 32x32 partial product per cycle
// depends on nothing outside this file
`timescale 1ns / 1ps

module bwlp_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod,
  output logic         done
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [1:0]   cnt;
  logic         busy;
  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [63:0]  pp;
  logic [1:0]   pos;

  assign a_part = cnt[1] ? a_r[63:32] : a_r[31:0];
  assign b_part = cnt[0] ? b_r[63:32] : b_r[31:0];
  assign pp     = 64'(a_part) * 64'(b_part);
  assign pos    = {1'b0, cnt[1]} + {1'b0, cnt[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      prod <= '0;
    end else if (busy) begin
      prod <= prod + (128'(pp) << {pos, 5'd0});
    end
  end

endmodule

[rtl/core/bwlp_div.sv]
// 64-bit unsigned restoring divider, one quotient bit per cycle
// depends on nothing outside this file
`timescale 1ns / 1ps

module bwlp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic [63:0] quo,
  output logic        done
);

  logic [64:0] rem_r;
  logic [63:0] dvs_r;
  logic [5:0]  cnt;
  logic        busy;
  logic [64:0] trial;
  logic        fits;

  assign trial = {rem_r[63:0], quo[63]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo   <= dividend;
    end else if (busy) begin
      rem_r <= fits ? (trial - {1'b0, dvs_r}) : trial;
      quo   <= {quo[62:0], fits};
    end
  end

endmodule

[rtl/core/bwlp_dpath.sv]
// datapath: histories, coefficient, tangent and filter arithmetic, output register
// depends on bwlp_pkg, bwlp_mul and bwlp_div
`timescale 1ns / 1ps

module bwlp_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  bwlp_pkg::cmd_t              cmd,
  output bwlp_pkg::stat_t             stat,
  input  bwlp_pkg::in_t               in_data,
  input  logic                        cfg_we,
  input  logic [bwlp_pkg::CUT_WIDTH-1:0] cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bwlp_pkg::out_t              out_data
);

  import bwlp_pkg::*;

  localparam logic signed [127:0] SAT_MAX = 128'sd2147483647;
  localparam logic signed [127:0] SAT_MIN = -128'sd2147483648;

  logic [CUT_WIDTH-1:0]           cutoff;
  logic signed [SAMPLE_WIDTH-1:0] ih0, ih1, ih2;
  logic signed [SAMPLE_WIDTH-1:0] oh0, oh1, oh2;
  logic [TS_WIDTH-1:0]            prev;
  logic [TS_WIDTH-1:0]            mag;
  logic                           first, mag_zero;
  logic signed [31:0]             coef;
  logic                           neg, big;
  logic [23:0]                    ph;
  logic [39:0]                    rv;
  logic [31:0]                    x, x2, p, tq;
  logic [63:0]                    cc, sc;
  logic [63:0]                    g, k1m, k2m;
  logic                           k1n, k2n;
  logic signed [127:0]            acc;
  logic [OP_WIDTH-1:0]            op_r;
  logic [STEP_WIDTH-1:0]          step_r;
  logic                           done_q;
  logic [63:0]                    num;
  logic [24:0]                    qe;

  logic         mul_start, div_start, mul_done, div_done;
  logic [63:0]  mul_a, mul_b, div_n, div_d;
  logic [127:0] prod;
  logic [63:0]  quo;

  logic [TS_WIDTH-1:0]   diff_f, diff_b;
  logic [23:0]           targ;
  logic [31:0]           cm;
  logic signed [63:0]    sc_s, den_raw, den, a1, a2;
  logic [63:0]           a1m, a2m;
  logic signed [33:0]    xs;
  logic [33:0]           xsm;
  logic [31:0]           y1m, y2m;
  logic [63:0]           r_est, r_fix;
  logic [24:0]           q_fix;
  logic [23:0]           ph_q, ph_f;
  logic                  neg_f;
  logic [31:0]           t_new, cmv;
  logic signed [127:0]   rnd, shv;
  logic signed [SAMPLE_WIDTH-1:0] y_new;
  logic signed [127:0]   term;

  bwlp_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .prod(prod), .done(mul_done)
  );

  bwlp_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_n), .divisor(div_d),
    .quo(quo), .done(div_done)
  );

  assign diff_f  = in_data.timestamp_ns - prev;
  assign diff_b  = prev - in_data.timestamp_ns;
  assign targ    = big ? (PH_HALF - ph) : ph;
  assign cm      = coef[31] ? 32'(-coef) : 32'(coef);
  assign sc_s    = coef[31] ? -$signed(sc) : $signed(sc);
  assign den_raw = 64'sd16777216 + $signed(cc) + sc_s;
  assign den     = (den_raw <= 64'sd0) ? 64'sd1 : den_raw;
  assign a1      = 64'sd33554432 - $signed(cc << 1);
  assign a2      = 64'sd16777216 + $signed(cc) - sc_s;
  assign a1m     = a1[63] ? 64'(-a1) : 64'(a1);
  assign a2m     = a2[63] ? 64'(-a2) : 64'(a2);
  assign xs      = 34'(ih2) + (34'(ih1) <<< 1) + 34'(ih0);
  assign xsm     = xs[33] ? 34'(-xs) : 34'(xs);
  assign y1m     = oh1[31] ? 32'(-oh1) : 32'(oh1);
  assign y2m     = oh2[31] ? 32'(-oh2) : 32'(oh2);

  // quotient estimate by 10^12 is at most one low, one compare fixes it
  assign r_est = num - prod[63:0];
  assign r_fix = (r_est >= TEN12) ? (r_est - TEN12) : r_est;
  assign q_fix = (r_est >= TEN12) ? (qe + 25'd1) : qe;

  // phase fold into [0, 1/2] half-turns
  assign ph_q  = q_fix[23:0];
  assign ph_f  = (ph_q >= PH_HALF) ? (PH_FULL_M1 - ph_q + 24'd1) : ph_q;
  assign neg_f = (ph_f == 24'd0) ? 1'b0 : ((ph_q >= PH_HALF) ? !neg : neg);

  assign t_new = prod[61:30];
  assign cmv   = big ? 32'(t_new >> 14) : C_LIMIT;

  assign rnd   = acc + 128'sd8388608;
  assign shv   = rnd >>> 24;
  assign y_new = (shv > SAT_MAX) ? SAMPLE_WIDTH'(SAT_MAX) :
                 (shv < SAT_MIN) ? SAMPLE_WIDTH'(SAT_MIN) : SAMPLE_WIDTH'(shv);

  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_n     = '0;
    div_d     = TEN12;
    if (cmd.go) begin
      unique case (cmd.op)
        OP_MOD1:   begin mul_start = 1'b1; mul_a = 64'(mag); mul_b = RECIP_TEN12; end
        OP_MULR:   begin mul_start = 1'b1; mul_a = 64'(rv); mul_b = 64'(cutoff); end
        OP_MOD2:   begin mul_start = 1'b1; mul_a = prod[63:0]; mul_b = RECIP_TEN12; end
        OP_PHASE:  begin mul_start = 1'b1; mul_a = {rv, 24'd0}; mul_b = RECIP_TEN12; end
        OP_FIX1, OP_FIX2, OP_FIXP: begin
          mul_start = 1'b1;
          mul_a     = 64'(qe);
          mul_b     = TEN12;
        end
        OP_MULX:   begin mul_start = 1'b1; mul_a = 64'(targ); mul_b = PI_Q30; end
        OP_MULX2:  begin mul_start = 1'b1; mul_a = 64'(x); mul_b = 64'(x); end
        OP_HORNER: begin mul_start = 1'b1; mul_a = 64'(p); mul_b = 64'(x2); end
        OP_MULT:   begin mul_start = 1'b1; mul_a = 64'(x); mul_b = 64'(p); end
        OP_DIVC:   begin div_start = 1'b1; div_n = 64'd1 << 46; div_d = 64'(tq); end
        OP_MULCC:  begin mul_start = 1'b1; mul_a = 64'(cm); mul_b = 64'(cm); end
        OP_MULSC:  begin mul_start = 1'b1; mul_a = SQRT2_Q30; mul_b = 64'(cm); end
        OP_DIVG:   begin div_start = 1'b1; div_n = 64'd1 << 48; div_d = 64'(den); end
        OP_DIVK1:  begin div_start = 1'b1; div_n = a1m << 24; div_d = 64'(den); end
        OP_DIVK2:  begin div_start = 1'b1; div_n = a2m << 24; div_d = 64'(den); end
        OP_ACC0:   begin mul_start = 1'b1; mul_a = g; mul_b = 64'(xsm); end
        OP_ACC1:   begin mul_start = 1'b1; mul_a = k2m; mul_b = 64'(y2m); end
        OP_ACC2:   begin mul_start = 1'b1; mul_a = k1m; mul_b = 64'(y1m); end
        default:   ;
      endcase
    end
  end

  // signed product term for the accumulate steps
  always_comb begin
    unique case (op_r)
      OP_ACC1: term = (k2n ^ oh2[31]) ? -$signed(prod) : $signed(prod);
      OP_ACC2: term = (k1n ^ oh1[31]) ? -$signed(prod) : $signed(prod);
      default: term = xs[33] ? -$signed(prod) : $signed(prod);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff    <= CUT_RESET;
      ih0 <= '0; ih1 <= '0; ih2 <= '0;
      oh0 <= '0; oh1 <= '0; oh2 <= '0;
      prev      <= '0;
      coef      <= C_RESET;
      first     <= 1'b1;
      mag_zero  <= 1'b1;
      done_q    <= 1'b0;
      out_valid <= 1'b0;
      op_r      <= OP_LOAD;
      step_r    <= '0;
    end else begin
      done_q <= mul_done | div_done;
      if (cfg_we) cutoff <= cfg_data;
      if (cmd.go && cmd.op == OP_EMIT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.go) begin
        op_r   <= cmd.op;
        step_r <= cmd.step;
      end
      if (cmd.go && (cmd.op == OP_MOD1 || cmd.op == OP_MOD2 || cmd.op == OP_PHASE)) begin
        num <= mul_a;
      end
      if (cmd.go && cmd.op == OP_LOAD) begin
        ih2   <= ih1;
        ih1   <= ih0;
        ih0   <= in_data.sample_value;
        prev  <= in_data.timestamp_ns;
        first <= (prev == '0);
        neg   <= in_data.timestamp_ns < prev;
        mag   <= (in_data.timestamp_ns < prev) ? diff_b : diff_f;
        mag_zero <= (in_data.timestamp_ns == prev);
      end
      if (cmd.go && cmd.op == OP_EMIT) begin
        out_data.updated <= cmd.updated;
        if (cmd.updated) begin
          oh2 <= oh1;
          oh1 <= oh0;
          oh0 <= y_new;
          out_data.filtered_value <= y_new;
        end else begin
          out_data.filtered_value <= oh0;
        end
      end
      if (mul_done || div_done) begin
        unique case (op_r)
          OP_MOD1, OP_MOD2, OP_PHASE: qe <= prod[127:103];
          OP_FIX1, OP_FIX2: rv <= r_fix[39:0];
          OP_FIXP: begin
            ph  <= ph_f;
            neg <= neg_f;
            big <= ph_f > PH_QUARTER;
          end
          OP_MULX:   x  <= prod[55:24];
          OP_MULX2: begin
            x2 <= prod[61:30];
            p  <= K7;
          end
          OP_HORNER: p  <= horner_coef(step_r) + prod[61:30];
          OP_MULT: begin
            tq <= t_new;
            if (big || t_new < TMIN_Q30) coef <= neg ? -$signed(cmv) : $signed(cmv);
          end
          OP_DIVC:   coef <= neg ? -$signed(quo[31:0]) : $signed(quo[31:0]);
          OP_MULCC:  cc <= prod[71:8];
          OP_MULSC:  sc <= prod[85:22];
          OP_DIVG:   g  <= quo;
          OP_DIVK1: begin
            k1m <= quo;
            k1n <= a1[63];
          end
          OP_DIVK2: begin
            k2m <= quo;
            k2n <= a2[63];
          end
          OP_ACC0:   acc <= term;
          OP_ACC1, OP_ACC2: acc <= acc - term;
          default: ;
        endcase
      end
    end
  end

  assign stat.done     = done_q;
  assign stat.first    = first;
  assign stat.mag_zero = mag_zero;
  assign stat.cut_zero = (cutoff == '0);
  assign stat.need_div = !big && (tq >= TMIN_Q30);
  assign stat.out_free = !out_valid || out_ready;

endmodule

[rtl/core/bwlp_ctrl.sv]
// controller: sequences the datapath operations for one sample
// depends on bwlp_pkg
`timescale 1ns / 1ps

module bwlp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bwlp_pkg::stat_t stat,
  output bwlp_pkg::cmd_t  cmd
);

  import bwlp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_ISSUE  = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]            state, state_next;
  logic [OP_WIDTH-1:0]   cur_op, cur_op_next;
  logic [STEP_WIDTH-1:0] step, step_next;
  logic                  upd, upd_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cur_op_next = cur_op;
    step_next   = step;
    upd_next    = upd;
    cmd.go      = 1'b0;
    cmd.op      = cur_op;
    cmd.step    = step;
    cmd.updated = upd;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.go     = 1'b1;
          cmd.op     = OP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.first || stat.mag_zero) begin
          upd_next   = 1'b0;
          state_next = S_EMIT;
        end else begin
          cur_op_next = stat.cut_zero ? OP_MULCC : OP_MOD1;
          state_next  = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.go     = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (stat.done) begin
          state_next = S_ISSUE;
          unique case (cur_op)
            OP_MOD1:  cur_op_next = OP_FIX1;
            OP_FIX1:  cur_op_next = OP_MULR;
            OP_MULR:  cur_op_next = OP_MOD2;
            OP_MOD2:  cur_op_next = OP_FIX2;
            OP_FIX2:  cur_op_next = OP_PHASE;
            OP_PHASE: cur_op_next = OP_FIXP;
            OP_FIXP:  cur_op_next = OP_MULX;
            OP_MULX:  cur_op_next = OP_MULX2;
            OP_MULX2: begin
              cur_op_next = OP_HORNER;
              step_next   = '0;
            end
            OP_HORNER: begin
              if (step == STEP_WIDTH'(HORNER_LAST)) cur_op_next = OP_MULT;
              else step_next = step + 1'b1;
            end
            OP_MULT:  cur_op_next = stat.need_div ? OP_DIVC : OP_MULCC;
            OP_DIVC:  cur_op_next = OP_MULCC;
            OP_MULCC: cur_op_next = OP_MULSC;
            OP_MULSC: cur_op_next = OP_DIVG;
            OP_DIVG:  cur_op_next = OP_DIVK1;
            OP_DIVK1: cur_op_next = OP_DIVK2;
            OP_DIVK2: cur_op_next = OP_ACC0;
            OP_ACC0:  cur_op_next = OP_ACC1;
            OP_ACC1:  cur_op_next = OP_ACC2;
            default: begin
              upd_next   = 1'b1;
              state_next = S_EMIT;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.go     = 1'b1;
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cur_op <= OP_MOD1;
      step   <= '0;
      upd    <= 1'b0;
    end else begin
      state  <= state_next;
      cur_op <= cur_op_next;
      step   <= step_next;
      upd    <= upd_next;
    end
  end

endmodule

[rtl/core/butterworth_lowpass_biquad.sv]
// top level of the timestamp-adaptive butterworth low-pass biquad
// depends on bwlp_pkg, bwlp_ctrl and bwlp_dpath
`timescale 1ns / 1ps

// Usage:
// in_valid/in_ready carry one sample with its nanosecond timestamp; out_valid/
// out_ready return one result (filtered value, updated flag) per input transaction.
// cfg_valid/cfg_ready writes the 20-bit cutoff in millihertz; cfg_ready is always
// high and a write should be made only while the block is idle.
// Paths per sample: a first sample or zero spacing emits the held value; a zero
// cutoff runs the filter only; otherwise the coefficients are updated in full,
// with the 1/tan divide when it is needed.
// The result becomes valid in the same cycle as the block becomes ready for the next input.
// Multiplies run on the shared 64x64 multiplier and divides on the 64-bit restoring
// divider; the modulo and phase steps by 10^12 use reciprocal multiplies, the
// divider handles up to four divisions.
// One sample is worked on at a time; the next input transaction is taken once the
// result sits in the output register, so a stalled receiver holds the block only
// when a second result is ready to be written.
// Synchronous reset clears the histories and previous timestamp, sets the
// coefficient to one and the cutoff to 10 Hz; no clearing pass is needed.

module butterworth_lowpass_biquad (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bwlp_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bwlp_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bwlp_pkg::CUT_WIDTH-1:0] cfg_data
);

  import bwlp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  bwlp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  bwlp_dpath u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .in_data(in_data),
    .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
